// ===== rtl/dnp3_transaction_correlator_macros.svh =====
// Assertion macros shared by the correlator modules.
`ifndef DNP3_TRANSACTION_CORRELATOR_MACROS_SVH
`define DNP3_TRANSACTION_CORRELATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define DNP3_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DNP3_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/dnp3tc_pkg.sv =====
// Shared constants, types and command/status structs for the correlator.
package dnp3tc_pkg;

  localparam int PEND_N = 64;
  localparam int STRM_N = 64;
  localparam int SCAN_N = (PEND_N > STRM_N) ? PEND_N : STRM_N;
  localparam int PAW    = $clog2(PEND_N);
  localparam int SAW    = $clog2(STRM_N);
  localparam int CW     = $clog2(SCAN_N + 1);

  localparam logic [7:0] FN_CONFIRM  = 8'd0;
  localparam logic [7:0] FN_NOACK    = 8'd6;
  localparam logic [7:0] FN_RESP_MIN = 8'd128;
  localparam logic [7:0] FN_UNSOL    = 8'd130;

  typedef enum logic [2:0] {
    K_LINK  = 3'd0,
    K_UNSOL = 3'd1,
    K_CONF  = 3'd2,
    K_REQ   = 3'd3,
    K_RESP  = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    ACT_LINK       = 3'd0,
    ACT_UNSOL_DONE = 3'd1,
    ACT_UNSOL_WAIT = 3'd2,
    ACT_CONFIRMED  = 3'd3,
    ACT_NOACK_DONE = 3'd4,
    ACT_REQ_WAIT   = 3'd5,
    ACT_RESP_DONE  = 3'd6,
    ACT_FRAG_WAIT  = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  typedef struct packed {
    logic [47:0] circ;
    logic [20:0] tag;
    logic [15:0] txn;
  } pend_ent_t;

  typedef struct packed {
    logic [63:0] key;
    logic [3:0]  seq;
  } strm_ent_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/dnp3tc_ctrl.sv =====
// Controller state machine: accept, table scan, commit.
`include "dnp3_transaction_correlator_macros.svh"
module dnp3tc_ctrl import dnp3tc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (status_i.scan_done) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  `DNP3_ASSERT_NXT(a_accept_scan, in_valid_i && !in_stall_o, state_q == ST_SCAN,
                   "accepted request did not start a scan")
  `DNP3_ASSERT_IMP(a_done_in_scan, cmd_o.commit, state_q == ST_COMMIT && status_i.out_free,
                   "commit outside commit state")

endmodule

// ===== rtl/dnp3tc_datapath.sv =====
// Datapath: frame registers, pending and stream tables, scan compare, result register.
`include "dnp3_transaction_correlator_macros.svh"
module dnp3tc_datapath import dnp3tc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_status_t  status_o,
  input  logic        has_app_layer_i,
  input  logic [7:0]  function_code_i,
  input  logic [3:0]  app_seq_i,
  input  logic [15:0] flow_id_i,
  input  logic [15:0] src_endpoint_i,
  input  logic [15:0] dst_endpoint_i,
  input  logic [15:0] link_src_i,
  input  logic [15:0] link_dst_i,
  input  logic [6:0]  flags_i,
  input  logic [15:0] indications_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [15:0] transaction_id_o,
  output logic        matched_o,
  output logic        is_control_o,
  output logic        seq_mismatch_o,
  output logic [3:0]  expected_seq_o,
  output logic        reuse_unresolved_o,
  output logic [15:0] unresolved_id_o,
  output logic        indications_flagged_o,
  output logic        table_full_o,
  output logic        stream_tracked_o
);

  // request registers
  logic        app_q;
  logic [7:0]  fn_q;
  logic [3:0]  seq_q;
  logic [15:0] flow_q, src_q, dst_q, la_q, lb_q, ind_q;
  logic [6:0]  fl_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      app_q <= has_app_layer_i;
      fn_q  <= function_code_i;
      seq_q <= app_seq_i;
      flow_q <= flow_id_i;
      src_q <= src_endpoint_i;
      dst_q <= dst_endpoint_i;
      la_q  <= link_src_i;
      lb_q  <= link_dst_i;
      fl_q  <= flags_i;
      ind_q <= indications_i;
    end
  end

  // frame decode and keys
  logic f_unsol, f_conf, f_first, f_final, f_ctrl, f_reord, f_iin;
  assign f_unsol = fl_q[0];
  assign f_conf  = fl_q[1];
  assign f_first = fl_q[2];
  assign f_final = fl_q[3];
  assign f_ctrl  = fl_q[4];
  assign f_reord = fl_q[5];
  assign f_iin   = fl_q[6];

  kind_e kind;
  always_comb begin
    if (!app_q)                                              kind = K_LINK;
    else if (fn_q == FN_UNSOL || (fn_q >= FN_RESP_MIN && f_unsol)) kind = K_UNSOL;
    else if (fn_q == FN_CONFIRM)                             kind = K_CONF;
    else if (fn_q < FN_RESP_MIN)                             kind = K_REQ;
    else                                                     kind = K_RESP;
  end

  logic [15:0] lo, hi, ep_a;
  logic [47:0] circ;
  logic [20:0] tag_a, tag_b;
  logic [63:0] skey;
  logic [3:0]  seq_nx;
  assign lo     = (la_q < lb_q) ? la_q : lb_q;
  assign hi     = (la_q < lb_q) ? lb_q : la_q;
  assign circ   = {flow_q, lo, hi};
  assign ep_a   = (kind == K_UNSOL || kind == K_REQ) ? src_q : dst_q;
  assign tag_a  = {ep_a, seq_q, (kind == K_UNSOL || kind == K_CONF)};
  assign seq_nx = seq_q + 4'd1;
  assign tag_b  = {dst_q, seq_nx, 1'b0};
  assign skey   = {flow_q, src_q, la_q, lb_q};

  // scan counter and compare stage
  logic [CW-1:0] cnt_q, cmp_idx_q;
  logic          cmp_en_q, scan_done, p_en, s_en;
  assign scan_done = (cnt_q == CW'(SCAN_N));
  assign p_en = cmp_en_q && (cmp_idx_q < CW'(PEND_N));
  assign s_en = cmp_en_q && (cmp_idx_q < CW'(STRM_N));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_idx_q <= '0;
      cmp_en_q  <= 1'b0;
    end else begin
      cmp_en_q  <= cmd_i.scan && !scan_done;
      cmp_idx_q <= cnt_q;
      if (cmd_i.start)                 cnt_q <= '0;
      else if (cmd_i.scan && !scan_done) cnt_q <= cnt_q + CW'(1);
    end
  end

  // table storage
  pend_ent_t pend_mem [PEND_N];
  strm_ent_t strm_mem [STRM_N];
  pend_ent_t prd_q;
  strm_ent_t srd_q;
  logic [PEND_N-1:0] pend_valid_q;
  logic [STRM_N-1:0] strm_valid_q;

  // commit controls
  logic           pw_en, clr_en, sw_en, alloc;
  logic [PAW-1:0] pw_idx;
  logic [SAW-1:0] sw_idx;
  logic [20:0]    pw_tag;
  logic [15:0]    pw_txn;

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && pw_en) pend_mem[pw_idx] <= '{circ: circ, tag: pw_tag, txn: pw_txn};
    if (cmd_i.scan && cnt_q < CW'(PEND_N)) prd_q <= pend_mem[cnt_q[PAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && sw_en) strm_mem[sw_idx] <= '{key: skey, seq: seq_q};
    if (cmd_i.scan && cnt_q < CW'(STRM_N)) srd_q <= strm_mem[cnt_q[SAW-1:0]];
  end

  // match capture: lowest index wins
  logic           a_hit_q, b_hit_q, f_hit_q, s_hit_q, sf_hit_q;
  logic [PAW-1:0] a_idx_q, b_idx_q, f_idx_q;
  logic [SAW-1:0] s_idx_q, sf_idx_q;
  logic [15:0]    a_txn_q;
  logic [3:0]     s_seq_q;
  logic           pv, sv;
  assign pv = pend_valid_q[cmp_idx_q[PAW-1:0]];
  assign sv = strm_valid_q[cmp_idx_q[SAW-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_hit_q <= 1'b0; b_hit_q <= 1'b0; f_hit_q <= 1'b0;
      s_hit_q <= 1'b0; sf_hit_q <= 1'b0;
      a_idx_q <= '0; b_idx_q <= '0; f_idx_q <= '0;
      s_idx_q <= '0; sf_idx_q <= '0;
      a_txn_q <= '0; s_seq_q <= '0;
    end else if (cmd_i.start) begin
      a_hit_q <= 1'b0; b_hit_q <= 1'b0; f_hit_q <= 1'b0;
      s_hit_q <= 1'b0; sf_hit_q <= 1'b0;
    end else begin
      if (p_en) begin
        if (pv && !a_hit_q && prd_q.circ == circ && prd_q.tag == tag_a) begin
          a_hit_q <= 1'b1;
          a_idx_q <= cmp_idx_q[PAW-1:0];
          a_txn_q <= prd_q.txn;
        end
        if (pv && !b_hit_q && prd_q.circ == circ && prd_q.tag == tag_b) begin
          b_hit_q <= 1'b1;
          b_idx_q <= cmp_idx_q[PAW-1:0];
        end
        if (!pv && !f_hit_q) begin
          f_hit_q <= 1'b1;
          f_idx_q <= cmp_idx_q[PAW-1:0];
        end
      end
      if (s_en) begin
        if (sv && !s_hit_q && srd_q.key == skey) begin
          s_hit_q <= 1'b1;
          s_idx_q <= cmp_idx_q[SAW-1:0];
          s_seq_q <= srd_q.seq;
        end
        if (!sv && !sf_hit_q) begin
          sf_hit_q <= 1'b1;
          sf_idx_q <= cmp_idx_q[SAW-1:0];
        end
      end
    end
  end

  // result and table update decisions
  logic [15:0] nxt_q;
  action_e     act;
  logic [15:0] txn, unres;
  logic        matched, is_ctrl, mism, reuse, iflag, full, tracked;
  logic [3:0]  exp_seq, expct;
  assign exp_seq = s_seq_q + 4'd1;

  always_comb begin
    act = ACT_LINK; txn = nxt_q; unres = '0; matched = 1'b0; is_ctrl = 1'b0;
    mism = 1'b0; expct = '0; reuse = 1'b0; iflag = 1'b0; full = 1'b0; tracked = 1'b0;
    pw_en = 1'b0; pw_idx = a_hit_q ? a_idx_q : f_idx_q; pw_tag = tag_a; pw_txn = nxt_q;
    clr_en = 1'b0; sw_en = 1'b0; sw_idx = s_hit_q ? s_idx_q : sf_idx_q; alloc = 1'b0;
    case (kind)
      K_LINK: begin
        alloc = 1'b1;
      end
      K_UNSOL: begin
        alloc = 1'b1;
        if (f_conf) begin
          act   = ACT_UNSOL_WAIT;
          pw_en = a_hit_q || f_hit_q;
          full  = !(a_hit_q || f_hit_q);
        end else begin
          act = ACT_UNSOL_DONE;
        end
      end
      K_CONF: begin
        act     = ACT_CONFIRMED;
        matched = a_hit_q;
        clr_en  = a_hit_q;
        txn     = a_hit_q ? a_txn_q : nxt_q;
        alloc   = !a_hit_q;
      end
      K_REQ: begin
        tracked = s_hit_q;
        mism    = s_hit_q && !f_reord && f_first && (seq_q != exp_seq);
        expct   = mism ? exp_seq : 4'd0;
        sw_en   = !f_reord && (s_hit_q || sf_hit_q);
        reuse   = a_hit_q;
        unres   = a_hit_q ? a_txn_q : 16'd0;
        clr_en  = a_hit_q;
        alloc   = 1'b1;
        is_ctrl = f_ctrl;
        full    = !f_reord && !s_hit_q && !sf_hit_q;
        if (fn_q == FN_NOACK) begin
          act = ACT_NOACK_DONE;
        end else begin
          act   = ACT_REQ_WAIT;
          pw_en = a_hit_q || f_hit_q;
          if (!(a_hit_q || f_hit_q)) full = 1'b1;
        end
      end
      K_RESP: begin
        matched = a_hit_q;
        clr_en  = a_hit_q;
        txn     = a_hit_q ? a_txn_q : nxt_q;
        alloc   = !a_hit_q;
        iflag   = f_iin && (ind_q != 16'd0);
        pw_txn  = a_hit_q ? a_txn_q : nxt_q;
        if (f_final) begin
          act = ACT_RESP_DONE;
        end else begin
          act    = ACT_FRAG_WAIT;
          pw_tag = tag_b;
          pw_idx = b_hit_q ? b_idx_q : (a_hit_q ? a_idx_q : f_idx_q);
          pw_en  = b_hit_q || a_hit_q || f_hit_q;
          full   = !(b_hit_q || a_hit_q || f_hit_q);
        end
      end
      default: begin
        alloc = 1'b0;
      end
    endcase
  end

  // valid bits and id counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= '0;
      strm_valid_q <= '0;
      nxt_q        <= '0;
    end else if (cmd_i.commit) begin
      if (clr_en) pend_valid_q[a_idx_q] <= 1'b0;
      if (pw_en)  pend_valid_q[pw_idx]  <= 1'b1;
      if (sw_en)  strm_valid_q[sw_idx]  <= 1'b1;
      if (alloc)  nxt_q <= nxt_q + 16'd1;
    end
  end

  // result register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      action_o              <= act;
      transaction_id_o      <= txn;
      matched_o             <= matched;
      is_control_o          <= is_ctrl;
      seq_mismatch_o        <= mism;
      expected_seq_o        <= expct;
      reuse_unresolved_o    <= reuse;
      unresolved_id_o       <= unres;
      indications_flagged_o <= iflag;
      table_full_o          <= full;
      stream_tracked_o      <= tracked;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.scan_done = scan_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  `DNP3_ASSERT_IMP(a_no_overwrite, cmd_i.commit, !(out_valid_q && out_stall_i),
                   "result overwritten while stalled")
  `DNP3_ASSERT_NXT(a_commit_shows, cmd_i.commit, out_valid_q,
                   "commit did not present a result")

endmodule

// ===== rtl/dnp3_transaction_correlator.sv =====
// Top level of the DNP3 transaction correlator.
// Takes one decoded frame per request and returns one result per frame. Each frame is
// matched against a 64-entry pending table and a 64-entry stream table by scanning both
// tables one entry per cycle through their memory read ports. A frame passes the accept,
// scan (read latency included) and commit states before the next is accepted; commit waits
// while a stalled result holds the output register; a finished result waits there while
// the next frame is taken. No clearing pass: the tables carry valid bits cleared by reset.
module dnp3_transaction_correlator import dnp3tc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        has_app_layer_i,
  input  logic [7:0]  function_code_i,
  input  logic [3:0]  app_seq_i,
  input  logic [15:0] flow_id_i,
  input  logic [15:0] src_endpoint_i,
  input  logic [15:0] dst_endpoint_i,
  input  logic [15:0] link_src_i,
  input  logic [15:0] link_dst_i,
  input  logic [6:0]  flags_i,
  input  logic [15:0] indications_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [15:0] transaction_id_o,
  output logic        matched_o,
  output logic        is_control_o,
  output logic        seq_mismatch_o,
  output logic [3:0]  expected_seq_o,
  output logic        reuse_unresolved_o,
  output logic [15:0] unresolved_id_o,
  output logic        indications_flagged_o,
  output logic        table_full_o,
  output logic        stream_tracked_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  dnp3tc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .status_i(status), .cmd_o(cmd)
  );

  dnp3tc_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .has_app_layer_i, .function_code_i, .app_seq_i, .flow_id_i,
    .src_endpoint_i, .dst_endpoint_i, .link_src_i, .link_dst_i,
    .flags_i, .indications_i,
    .out_valid_o, .out_stall_i, .action_o, .transaction_id_o, .matched_o,
    .is_control_o, .seq_mismatch_o, .expected_seq_o, .reuse_unresolved_o,
    .unresolved_id_o, .indications_flagged_o, .table_full_o, .stream_tracked_o
  );

endmodule

// ===== bench/dnp3_transaction_correlator_test.sv =====
// Self-checking testbench for the DNP3 transaction correlator: random and directed frames.
`timescale 1ns / 100ps

module dnp3_transaction_correlator_test import dnp3tc_pkg::*;;

  localparam int NPEND   = PEND_N;
  localparam int NSTRM   = STRM_N;
  localparam int N_RAND  = 760;
  localparam int LATENCY = 200;
  localparam int LIMIT   = 400000;

  typedef struct packed {
    logic        has_app;
    logic [7:0]  fn;
    logic [3:0]  seq;
    logic [15:0] flow;
    logic [15:0] src;
    logic [15:0] dst;
    logic [15:0] la;
    logic [15:0] lb;
    logic [6:0]  fl;
    logic [15:0] ind;
  } frame_t;

  typedef struct packed {
    action_e     action;
    logic [15:0] txn;
    logic        matched;
    logic        is_ctrl;
    logic        mism;
    logic [3:0]  exp_seq;
    logic        reuse;
    logic [15:0] unres;
    logic        iflag;
    logic        full;
    logic        tracked;
  } verdict_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  frame_t drv;
  logic [2:0]  action_o;
  logic [15:0] transaction_id_o, unresolved_id_o;
  logic        matched_o, is_control_o, seq_mismatch_o, reuse_unresolved_o;
  logic [3:0]  expected_seq_o;
  logic        indications_flagged_o, table_full_o, stream_tracked_o;

  dnp3_transaction_correlator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .has_app_layer_i(drv.has_app), .function_code_i(drv.fn), .app_seq_i(drv.seq),
    .flow_id_i(drv.flow), .src_endpoint_i(drv.src), .dst_endpoint_i(drv.dst),
    .link_src_i(drv.la), .link_dst_i(drv.lb), .flags_i(drv.fl),
    .indications_i(drv.ind),
    .out_valid_o, .out_stall_i, .action_o, .transaction_id_o, .matched_o,
    .is_control_o, .seq_mismatch_o, .expected_seq_o, .reuse_unresolved_o,
    .unresolved_id_o, .indications_flagged_o, .table_full_o, .stream_tracked_o
  );

  // Predictor state
  logic [47:0] pc_circ [NPEND];
  logic [20:0] pc_tag  [NPEND];
  logic [15:0] pc_txn  [NPEND];
  logic        pc_vld  [NPEND];
  logic [63:0] sk_key  [NSTRM];
  logic [3:0]  sk_seq  [NSTRM];
  logic        sk_vld  [NSTRM];
  logic [15:0] txn_ctr;

  frame_t   frame_q[$];
  verdict_t verdict_q[$];
  int errors, cycles;
  bit stim_done, hold_off;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] alloc_txn();
    alloc_txn = txn_ctr;
    txn_ctr = txn_ctr + 16'd1;
  endfunction

  function automatic logic [20:0] pack_tag(logic [15:0] ep, logic [3:0] s, logic u);
    return {ep, s, u};
  endfunction

  function automatic int pend_lookup(logic [47:0] c, logic [20:0] t);
    for (int i = 0; i < NPEND; i++)
      if (pc_vld[i] && pc_circ[i] == c && pc_tag[i] == t) return i;
    return -1;
  endfunction

  // returns 1 when the insert is dropped
  function automatic logic pend_insert(logic [47:0] c, logic [20:0] t, logic [15:0] id);
    int i;
    i = pend_lookup(c, t);
    if (i < 0)
      for (int k = 0; k < NPEND; k++)
        if (!pc_vld[k]) begin
          i = k;
          break;
        end
    if (i < 0) return 1'b1;
    pc_vld[i] = 1'b1;
    pc_circ[i] = c;
    pc_tag[i] = t;
    pc_txn[i] = id;
    return 1'b0;
  endfunction

  function automatic verdict_t correlate(frame_t f);
    verdict_t v;
    logic [15:0] lo, hi, id;
    logic [47:0] circ;
    logic [63:0] skey;
    logic [20:0] tag;
    logic [3:0]  nxt;
    int i, s;
    v = '0;
    lo = (f.la < f.lb) ? f.la : f.lb;
    hi = (f.la < f.lb) ? f.lb : f.la;
    circ = {f.flow, lo, hi};
    if (!f.has_app) begin
      v.action = ACT_LINK;
      v.txn = alloc_txn();
    end else if (f.fn == FN_UNSOL || (f.fn >= FN_RESP_MIN && f.fl[0])) begin
      v.txn = alloc_txn();
      if (f.fl[1]) begin
        v.full = pend_insert(circ, pack_tag(f.src, f.seq, 1'b1), v.txn);
        v.action = ACT_UNSOL_WAIT;
      end else v.action = ACT_UNSOL_DONE;
    end else if (f.fn == FN_CONFIRM) begin
      i = pend_lookup(circ, pack_tag(f.dst, f.seq, 1'b1));
      if (i >= 0) begin
        pc_vld[i] = 1'b0;
        v.txn = pc_txn[i];
        v.matched = 1'b1;
      end else v.txn = alloc_txn();
      v.action = ACT_CONFIRMED;
    end else if (f.fn < FN_RESP_MIN) begin
      // request: stream sequence check, then pending insert
      tag = pack_tag(f.src, f.seq, 1'b0);
      skey = {f.flow, f.src, f.la, f.lb};
      s = -1;
      for (int k = 0; k < NSTRM; k++)
        if (s < 0 && sk_vld[k] && sk_key[k] == skey) s = k;
      if (s >= 0) begin
        nxt = sk_seq[s] + 4'd1;
        v.tracked = 1'b1;
        if (!f.fl[5] && f.fl[2] && f.seq != nxt) begin
          v.mism = 1'b1;
          v.exp_seq = nxt;
        end
      end
      if (!f.fl[5]) begin
        if (s < 0)
          for (int k = 0; k < NSTRM; k++)
            if (s < 0 && !sk_vld[k]) s = k;
        if (s < 0) v.full = 1'b1;
        else begin
          sk_vld[s] = 1'b1;
          sk_key[s] = skey;
          sk_seq[s] = f.seq;
        end
      end
      i = pend_lookup(circ, tag);
      if (i >= 0) begin
        pc_vld[i] = 1'b0;
        v.reuse = 1'b1;
        v.unres = pc_txn[i];
      end
      v.txn = alloc_txn();
      v.is_ctrl = f.fl[4];
      if (f.fn == FN_NOACK) v.action = ACT_NOACK_DONE;
      else begin
        if (pend_insert(circ, tag, v.txn)) v.full = 1'b1;
        v.action = ACT_REQ_WAIT;
      end
    end else begin
      i = pend_lookup(circ, pack_tag(f.dst, f.seq, 1'b0));
      if (i >= 0) begin
        pc_vld[i] = 1'b0;
        id = pc_txn[i];
        v.matched = 1'b1;
      end else id = alloc_txn();
      v.txn = id;
      if (f.fl[3]) v.action = ACT_RESP_DONE;
      else begin
        v.full = pend_insert(circ, pack_tag(f.dst, f.seq + 4'd1, 1'b0), id);
        v.action = ACT_FRAG_WAIT;
      end
      v.iflag = f.fl[6] && f.ind != 16'd0;
    end
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Frame generators
  function automatic frame_t rand_frame();
    frame_t f;
    f.has_app = 1'b1;
    f.fn = 8'($urandom_range(0, 255));
    f.seq = 4'($urandom);
    f.flow = 16'($urandom);
    f.src = 16'($urandom);
    f.dst = 16'($urandom);
    f.la = 16'($urandom);
    f.lb = 16'($urandom);
    f.fl = 7'($urandom);
    f.ind = 16'($urandom);
    return f;
  endfunction

  // Small field pool so keys collide and transactions get matched
  function automatic frame_t pool_frame();
    frame_t f;
    int r;
    f = rand_frame();
    f.has_app = ($urandom_range(0, 19) != 0);
    r = $urandom_range(0, 9);
    f.fn = (r < 3) ? 8'(1 + $urandom_range(0, 4)) : (r < 4) ? FN_NOACK :
           (r < 5) ? FN_CONFIRM : (r < 6) ? FN_UNSOL : (r < 9) ? 8'd129 :
           8'($urandom_range(0, 255));
    f.flow = 16'($urandom_range(0, 1));
    f.src = 16'($urandom_range(1, 2));
    f.dst = 16'd3 - f.src;
    f.la = 16'($urandom_range(10, 11));
    f.lb = 16'($urandom_range(10, 11));
    f.seq = 4'($urandom_range(0, 3));
    return f;
  endfunction

  // Stimulus
  initial begin
    frame_t f, g;
    errors = 0;
    stim_done = 0;
    for (int i = 0; i < NPEND; i++) pc_vld[i] = 0;
    for (int i = 0; i < NSTRM; i++) sk_vld[i] = 0;
    txn_ctr = 0;
    // directed: link frame, extremes, request/response pair, confirm, fragments
    f = '0;
    frame_q.push_back(f);
    f = '1;
    frame_q.push_back(f);
    f = '1; f.has_app = 1; f.fn = 8'd255; f.fl = 7'h00;
    frame_q.push_back(f);
    f = '0; f.has_app = 1; f.fn = 8'd1; f.src = 16'd5; f.dst = 16'd9;
    f.la = 16'd200; f.lb = 16'd100; f.fl = 7'h1c; f.seq = 4'd15;
    frame_q.push_back(f);
    g = f; g.seq = 4'd3;
    frame_q.push_back(g);
    frame_q.push_back(f);
    g = f; g.fl = 7'h24; g.seq = 4'd7;
    frame_q.push_back(g);
    g = f; g.fn = 8'd129; g.src = 16'd9; g.dst = 16'd5; g.la = 16'd100; g.lb = 16'd200;
    g.fl = 7'h40; g.ind = 16'h8000;
    frame_q.push_back(g);
    g.seq = 4'd0; g.fl = 7'h48;
    frame_q.push_back(g);
    g = f; g.fn = FN_NOACK; g.seq = 4'd0;
    frame_q.push_back(g);
    g = f; g.fn = FN_UNSOL; g.fl = 7'h02; g.src = 16'd9;
    frame_q.push_back(g);
    g.fn = FN_CONFIRM; g.src = 16'd5; g.dst = 16'd9; g.fl = 7'h00;
    frame_q.push_back(g);
    g.fn = 8'd131; g.fl = 7'h01;
    frame_q.push_back(g);
    g.fn = FN_CONFIRM; g.seq = 4'd9;
    frame_q.push_back(g);
    // fill both tables to force drops
    for (int i = 0; i < 70; i++) begin
      f = '0; f.has_app = 1; f.fn = 8'd2; f.flow = 16'(i + 100); f.fl = 7'h04;
      f.seq = 4'(i);
      frame_q.push_back(f);
    end
    // drain the pending table again with matching final responses
    for (int i = 0; i < 70; i++) begin
      f = '0; f.has_app = 1; f.fn = 8'd129; f.flow = 16'(i + 100); f.fl = 7'h08;
      f.seq = 4'(i);
      frame_q.push_back(f);
    end
    for (int i = 0; i < N_RAND; i++)
      frame_q.push_back(($urandom_range(0, 3) == 0) ? rand_frame() : pool_frame());
    stim_done = 1;
  end

  // Reset and run control
  initial begin
    rst_ni = 0;
    hold_off = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    wait (stim_done && frame_q.size() == 0 && !in_valid_i && verdict_q.size() == 0);
    repeat (LATENCY) @(posedge clk_i);
    if (errors == 0 && verdict_q.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end
  initial cycles = 0;

  // Long receiver hold-off once the run is under way
  initial begin
    wait (rst_ni);
    repeat (30000) @(posedge clk_i);
    hold_off <= 1;
    repeat (2000) @(posedge clk_i);
    hold_off <= 0;
  end

  // Driver: one request at a time, random gap before each
  int gap;
  initial begin
    in_valid_i = 0;
    drv = '0;
    gap = 0;
  end
  always @(posedge clk_i) begin
    int d;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q.push_back(correlate(drv));
        d = $urandom_range(0, 4);
        if (d == 0 && frame_q.size() > 0) begin
          drv <= frame_q.pop_front();
          gap <= 0;
        end else begin
          in_valid_i <= 0;
          gap <= (d > 0) ? d - 1 : 0;
        end
      end else if (!in_valid_i) begin
        if (gap > 0) gap <= gap - 1;
        else if (frame_q.size() > 0) begin
          drv <= frame_q.pop_front();
          in_valid_i <= 1;
        end
      end
    end
  end

  // Monitor with random output stalls
  int wait_n;
  initial begin
    out_stall_i = 1;
    wait_n = 0;
  end
  always @(posedge clk_i) begin
    verdict_t w;
    int d;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (verdict_q.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          w = verdict_q.pop_front();
          if (action_o != w.action) report_mismatch("action", action_o, w.action);
          if (transaction_id_o != w.txn)
            report_mismatch("transaction_id", transaction_id_o, w.txn);
          if (matched_o != w.matched) report_mismatch("matched", matched_o, w.matched);
          if (is_control_o != w.is_ctrl)
            report_mismatch("is_control", is_control_o, w.is_ctrl);
          if (seq_mismatch_o != w.mism)
            report_mismatch("seq_mismatch", seq_mismatch_o, w.mism);
          if (expected_seq_o != w.exp_seq)
            report_mismatch("expected_seq", expected_seq_o, w.exp_seq);
          if (reuse_unresolved_o != w.reuse)
            report_mismatch("reuse_unresolved", reuse_unresolved_o, w.reuse);
          if (unresolved_id_o != w.unres)
            report_mismatch("unresolved_id", unresolved_id_o, w.unres);
          if (indications_flagged_o != w.iflag)
            report_mismatch("indications_flagged", indications_flagged_o, w.iflag);
          if (table_full_o != w.full) report_mismatch("table_full", table_full_o, w.full);
          if (stream_tracked_o != w.tracked)
            report_mismatch("stream_tracked", stream_tracked_o, w.tracked);
        end
        d = $urandom_range(0, 4);
        wait_n <= (d > 0) ? d - 1 : 0;
        out_stall_i <= (d > 0) || hold_off;
      end else if (hold_off) out_stall_i <= 1;
      else if (wait_n > 0) begin
        wait_n <= wait_n - 1;
        out_stall_i <= 1;
      end else out_stall_i <= 0;
    end
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/dnp3tc_pkg.sv
rtl/dnp3tc_ctrl.sv
rtl/dnp3tc_datapath.sv
rtl/dnp3_transaction_correlator.sv
bench/dnp3_transaction_correlator_test.sv
